[src/hsi2rgb_pkg.sv]
// Shared constants, types and the hue ratio table for the HSI to RGB converter.
// No dependencies; used by hsi_to_rgb_converter_core.
`default_nettype none

package hsi2rgb_pkg;

  localparam int CHANNEL_BITS        = 8;
  localparam int RATIO_FRACTION_BITS = 10;

  localparam int HUE_W      = 9;
  localparam int HUE_MAX    = 359;
  localparam int SECTOR_DEG = 120;
  localparam int H_W        = 7;

  // Q30 one-degree rotation used to build the ratio table
  localparam int     TRIG_BITS   = 30;
  localparam longint COS_ONE_DEG = 64'sd1073578288;
  localparam longint SIN_ONE_DEG = 64'sd18739379;

  localparam int CH_MAX   = (1 << CHANNEL_BITS) - 1;
  localparam int HALF_MAX = CH_MAX / 2;
  localparam int RECIP    = (1 << CHANNEL_BITS) + 1;

  // ratio lies in (-1, 2], one - ratio in [-1, 2)
  localparam int RATIO_W = RATIO_FRACTION_BITS + 3;
  localparam int IS_W    = 2 * CHANNEL_BITS;
  localparam int PROD_W  = IS_W + 1 + RATIO_W;
  localparam int DIVY_W  = PROD_W + 1 - RATIO_FRACTION_BITS;
  localparam int REC_W   = DIVY_W + CHANNEL_BITS + 1;
  localparam int EST_W   = REC_W - 2 * CHANNEL_BITS;
  localparam int Q_W     = CHANNEL_BITS + 2;
  localparam int VAL_W   = CHANNEL_BITS + 3;

  // rounding bias for a divide by CH_MAX * 2^F
  localparam int ROUND_BIAS = CH_MAX * (1 << (RATIO_FRACTION_BITS - 1));

  localparam int S_TDATA_W = ((HUE_W + 2 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    SECTOR_RG = 2'd0,
    SECTOR_GB = 2'd1,
    SECTOR_BR = 2'd2
  } sector_e;

  typedef logic signed [RATIO_W-1:0] ratio_t;
  typedef ratio_t [SECTOR_DEG-1:0]   ratio_rom_t;

  // cos(h)/cos(60-h) with F fraction bits, from a Q30 rotation by one degree
  // per entry; every step rounds to nearest, ties away from zero.
  function automatic ratio_rom_t build_ratio_rom();
    ratio_rom_t rom;
    longint     cs [SECTOR_DEG];
    longint     c, s, nc, ns, num, mag, q, den, rem;
    longint     half_unit;
    int         k, d, b;
    half_unit = 64'sd1 <<< (TRIG_BITS - 1);
    c = 64'sd1 <<< TRIG_BITS;
    s = 64'sd0;
    for (k = 0; k < SECTOR_DEG; k++) begin
      cs[k] = c;
      num = c * COS_ONE_DEG - s * SIN_ONE_DEG;
      mag = (num < 0) ? -num : num;
      q   = (mag + half_unit) >>> TRIG_BITS;
      nc  = (num < 0) ? -q : q;
      num = s * COS_ONE_DEG + c * SIN_ONE_DEG;
      mag = (num < 0) ? -num : num;
      q   = (mag + half_unit) >>> TRIG_BITS;
      ns  = (num < 0) ? -q : q;
      c = nc;
      s = ns;
    end
    for (k = 0; k < SECTOR_DEG; k++) begin
      d   = (k < 60) ? 60 - k : k - 60;
      den = cs[d];
      num = cs[k] <<< RATIO_FRACTION_BITS;
      mag = (num < 0) ? -num : num;
      mag = mag + (den >>> 1);
      // shift-and-subtract long division, den is positive
      q   = 64'sd0;
      rem = 64'sd0;
      for (b = 62; b >= 0; b--) begin
        rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
        q   = q <<< 1;
        if (rem >= den) begin
          rem = rem - den;
          q   = q | 64'sd1;
        end
      end
      q   = (num < 0) ? -q : q;
      rom[k] = RATIO_W'(q);
    end
    return rom;
  endfunction

  localparam ratio_rom_t RATIO_ROM = build_ratio_rom();

endpackage

`default_nettype wire

[src/hsi_to_rgb_converter_core.sv]
// HSI to RGB pixel converter: six-stage pipeline with a constant ratio table.
// Depends on hsi2rgb_pkg.
// Throughput: one pixel per cycle while the output is not stalled; each
// stage advances when the next one is empty or moving, so bubbles collapse
// and a stalled output holds its data.
// Reset (rst_ni low, asynchronous) clears all stage valid bits only.
`default_nettype none

module hsi_to_rgb_converter_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // {intensity, saturation, hue} from bit 0: hue[8:0], saturation, intensity
  input  wire logic [hsi2rgb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // from bit 0: red, green, blue
  output      logic [hsi2rgb_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  localparam int NS  = 6;
  localparam int CB  = hsi2rgb_pkg::CHANNEL_BITS;
  localparam int F   = hsi2rgb_pkg::RATIO_FRACTION_BITS;
  localparam int HW  = hsi2rgb_pkg::HUE_W;
  localparam int PW  = hsi2rgb_pkg::PROD_W;
  localparam int YW  = hsi2rgb_pkg::DIVY_W;
  localparam int RW  = hsi2rgb_pkg::REC_W;
  localparam int EW  = hsi2rgb_pkg::EST_W;
  localparam int QW  = hsi2rgb_pkg::Q_W;
  localparam int VW  = hsi2rgb_pkg::VAL_W;
  localparam int ISW = hsi2rgb_pkg::IS_W;
  localparam int RTW = hsi2rgb_pkg::RATIO_W;

  // stage valids and advance enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage 1: sector select, hue reduce, I*S
  logic [HW-1:0]                 hue_in, hue_c;
  logic [CB-1:0]                 sat_in, int_in;
  hsi2rgb_pkg::sector_e          s1_sector_d, s1_sector_q;
  logic [hsi2rgb_pkg::H_W-1:0]   s1_h_d, s1_h_q;
  logic [ISW-1:0]                s1_is_q;
  logic [CB-1:0]                 s1_int_q;

  assign hue_in = s_axis_tdata[HW-1:0];
  assign sat_in = s_axis_tdata[HW+CB-1:HW];
  assign int_in = s_axis_tdata[HW+2*CB-1:HW+CB];

  always_comb begin
    hue_c = (hue_in > HW'(hsi2rgb_pkg::HUE_MAX)) ? HW'(hsi2rgb_pkg::HUE_MAX) : hue_in;
    if (hue_c >= HW'(2 * hsi2rgb_pkg::SECTOR_DEG)) begin
      s1_sector_d = hsi2rgb_pkg::SECTOR_BR;
      s1_h_d = hsi2rgb_pkg::H_W'(hue_c - HW'(2 * hsi2rgb_pkg::SECTOR_DEG));
    end else if (hue_c >= HW'(hsi2rgb_pkg::SECTOR_DEG)) begin
      s1_sector_d = hsi2rgb_pkg::SECTOR_GB;
      s1_h_d = hsi2rgb_pkg::H_W'(hue_c - HW'(hsi2rgb_pkg::SECTOR_DEG));
    end else begin
      s1_sector_d = hsi2rgb_pkg::SECTOR_RG;
      s1_h_d = hsi2rgb_pkg::H_W'(hue_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sector_q <= s1_sector_d;
      s1_h_q      <= s1_h_d;
      s1_is_q     <= ISW'(sat_in) * ISW'(int_in);
      s1_int_q    <= int_in;
    end
  end

  // ---------------- stage 2: ratio table lookup
  hsi2rgb_pkg::sector_e     s2_sector_q;
  logic signed [RTW-1:0]    s2_ratio_d, s2_ratio_q, s2_om_q;
  logic [ISW-1:0]           s2_is_q;
  logic [CB-1:0]            s2_int_q;

  assign s2_ratio_d = $signed(hsi2rgb_pkg::RATIO_ROM[s1_h_q]);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_sector_q <= s1_sector_q;
      s2_ratio_q  <= s2_ratio_d;
      s2_om_q     <= $signed(RTW'(1 << F)) - s2_ratio_d;
      s2_is_q     <= s1_is_q;
      s2_int_q    <= s1_int_q;
    end
  end

  // ---------------- stage 3: I*S times ratio and one - ratio
  hsi2rgb_pkg::sector_e     s3_sector_q;
  logic signed [PW-1:0]     s3_p1_q, s3_p2_q;
  logic [YW-1:0]            s3_y3_q;
  logic [CB-1:0]            s3_int_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_sector_q <= s2_sector_q;
      s3_p1_q     <= PW'($signed({1'b0, s2_is_q})) * PW'(s2_ratio_q);
      s3_p2_q     <= PW'($signed({1'b0, s2_is_q})) * PW'(s2_om_q);
      s3_y3_q     <= YW'(s2_is_q) + YW'(hsi2rgb_pkg::HALF_MAX);
      s3_int_q    <= s2_int_q;
    end
  end

  // ---------------- stage 4: magnitude, round, reciprocal estimate of y / M
  logic [PW-1:0]  mag1, mag2;
  logic [PW:0]    x1, x2;
  logic [YW-1:0]  y1, y2;
  logic [RW-1:0]  rec1, rec2, rec3;

  always_comb begin
    mag1 = s3_p1_q[PW-1] ? PW'(-s3_p1_q) : PW'(s3_p1_q);
    mag2 = s3_p2_q[PW-1] ? PW'(-s3_p2_q) : PW'(s3_p2_q);
    x1   = (PW+1)'(mag1) + (PW+1)'(hsi2rgb_pkg::ROUND_BIAS);
    x2   = (PW+1)'(mag2) + (PW+1)'(hsi2rgb_pkg::ROUND_BIAS);
    y1   = YW'(x1 >> F);
    y2   = YW'(x2 >> F);
    rec1 = RW'(y1) * RW'(hsi2rgb_pkg::RECIP);
    rec2 = RW'(y2) * RW'(hsi2rgb_pkg::RECIP);
    rec3 = RW'(s3_y3_q) * RW'(hsi2rgb_pkg::RECIP);
  end

  hsi2rgb_pkg::sector_e     s4_sector_q;
  logic [YW-1:0]            s4_y_q   [3];
  logic [EW-1:0]            s4_est_q [3];
  logic [1:0]               s4_neg_q;
  logic [CB-1:0]            s4_int_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_sector_q <= s3_sector_q;
      s4_y_q[0]   <= y1;
      s4_y_q[1]   <= y2;
      s4_y_q[2]   <= s3_y3_q;
      s4_est_q[0] <= rec1[RW-1:2*CB];
      s4_est_q[1] <= rec2[RW-1:2*CB];
      s4_est_q[2] <= rec3[RW-1:2*CB];
      s4_neg_q    <= {s3_p2_q[PW-1], s3_p1_q[PW-1]};
      s4_int_q    <= s3_int_q;
    end
  end

  // ---------------- stage 5: one-step quotient correction
  logic [YW-1:0]  rem   [3];
  logic [QW-1:0]  q_d   [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rem[j] = s4_y_q[j] - ((YW'(s4_est_q[j]) << CB) - YW'(s4_est_q[j]));
      q_d[j] = (rem[j] >= YW'(hsi2rgb_pkg::CH_MAX)) ? QW'(s4_est_q[j] + EW'(1))
                                                    : QW'(s4_est_q[j]);
    end
  end

  hsi2rgb_pkg::sector_e     s5_sector_q;
  logic [QW-1:0]            s5_q_q [3];
  logic [1:0]               s5_neg_q;
  logic [CB-1:0]            s5_int_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_sector_q <= s4_sector_q;
      s5_q_q      <= q_d;
      s5_neg_q    <= s4_neg_q;
      s5_int_q    <= s4_int_q;
    end
  end

  // ---------------- stage 6: apply to intensity, saturate, rotate by sector
  logic signed [VW-1:0] val   [3];
  logic [CB-1:0]        chan  [3];
  logic [CB-1:0]        red_d, green_d, blue_d;

  always_comb begin
    val[0] = s5_neg_q[0] ? $signed(VW'(s5_int_q)) - $signed(VW'(s5_q_q[0]))
                         : $signed(VW'(s5_int_q)) + $signed(VW'(s5_q_q[0]));
    val[1] = s5_neg_q[1] ? $signed(VW'(s5_int_q)) - $signed(VW'(s5_q_q[1]))
                         : $signed(VW'(s5_int_q)) + $signed(VW'(s5_q_q[1]));
    val[2] = $signed(VW'(s5_int_q)) - $signed(VW'(s5_q_q[2]));
    for (int j = 0; j < 3; j++) begin
      if (val[j] < 0) begin
        chan[j] = '0;
      end else if (val[j] > $signed(VW'(hsi2rgb_pkg::CH_MAX))) begin
        chan[j] = CB'(hsi2rgb_pkg::CH_MAX);
      end else begin
        chan[j] = CB'(val[j]);
      end
    end
    unique case (s5_sector_q)
      hsi2rgb_pkg::SECTOR_RG: begin
        red_d = chan[0]; green_d = chan[1]; blue_d = chan[2];
      end
      hsi2rgb_pkg::SECTOR_GB: begin
        green_d = chan[0]; blue_d = chan[1]; red_d = chan[2];
      end
      hsi2rgb_pkg::SECTOR_BR: begin
        blue_d = chan[0]; red_d = chan[1]; green_d = chan[2];
      end
      default: begin
        red_d = chan[0]; green_d = chan[1]; blue_d = chan[2];
      end
    endcase
  end

  logic [CB-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign m_axis_tdata = hsi2rgb_pkg::M_TDATA_W'({blue_q, green_q, red_q});

endmodule

`default_nettype wire
